// ===== sv/assert_macros.svh =====
// Assertion helpers for the RTL files; fvn_ctrl includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks an implication at every rising edge outside reset.
`define ASSERT_SYNC(label, clk_s, rst_s, prop) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (prop)) \
    else $error("assertion failed");

// Checks that a condition never holds outside reset.
`define ASSERT_NEVER(label, clk_s, rst_s, cond) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) !(cond)) \
    else $error("forbidden condition seen");

`endif

// ===== sv/fvn_pkg.sv =====
// ----------------------------------------------------------------------------
// fvn_pkg
// Shared types, constants and the per-octave step program of the noise block.
// ----------------------------------------------------------------------------
package fvn_pkg;

  // Octave index width, large enough for the widest supported octave count.
  localparam int OCT_W = 4;
  localparam int STEP_W = 5;
  localparam logic [STEP_W-1:0] LAST_STEP = 5'd26;

  localparam logic [31:0] HASH_MUL_A = 32'd15731;
  localparam logic [31:0] HASH_ADD_A = 32'd789221;
  localparam logic [31:0] HASH_ADD_B = 32'd1376312589;
  localparam logic [31:0] CORNER_ONE = 32'h8000_0000;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_SX_SQ,
    OP_SX_MUL,
    OP_SY_SQ,
    OP_SY_MUL,
    OP_HN,
    OP_H1,
    OP_H2,
    OP_H3,
    OP_BLA,
    OP_BLB,
    OP_ACC,
    OP_FIN
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [1:0]       sel;
    logic [OCT_W-1:0] oct;
  } cmd_t;

  // One octave: four smoothstep steps, four hashed corners of four steps,
  // three blends of two steps, then the accumulate.
  function automatic cmd_t step_cmd(input logic [STEP_W-1:0] step);
    cmd_t c;
    logic [STEP_W-1:0] hs;
    logic [STEP_W-1:0] bs;
    c.op  = OP_NOP;
    c.sel = 2'd0;
    c.oct = '0;
    hs = step - 5'd4;
    bs = step - 5'd20;
    if (step < 5'd4) begin
      case (step[1:0])
        2'd0:    c.op = OP_SX_SQ;
        2'd1:    c.op = OP_SX_MUL;
        2'd2:    c.op = OP_SY_SQ;
        default: c.op = OP_SY_MUL;
      endcase
    end else if (step < 5'd20) begin
      c.sel = hs[3:2];
      case (hs[1:0])
        2'd0:    c.op = OP_HN;
        2'd1:    c.op = OP_H1;
        2'd2:    c.op = OP_H2;
        default: c.op = OP_H3;
      endcase
    end else if (step < 5'd26) begin
      c.sel = bs[2:1];
      c.op  = bs[0] ? OP_BLB : OP_BLA;
    end else begin
      c.op = OP_ACC;
    end
    return c;
  endfunction

endpackage

// ===== sv/fractal_value_noise_2d.sv =====
// ----------------------------------------------------------------------------
// fractal_value_noise_2d
// Fractal value noise over a 2D fixed point sample, one result per sample.
// ----------------------------------------------------------------------------
// Usage: a sample beat on the s_ channel carries x, y, seed and octave count.
// The block takes one sample at a time; s_tready is high only while idle.
// The sequencer walks its step program once per octave and shares a single
// multiplier among smoothstep, four corner hashes, three blends and normalization.
// A sample with N octaves (zero counts as one, clamped to MAX_OCTAVES) runs
// N passes of the step program after acceptance, then a final normalization
// step registers its result and the sequencer returns to idle, where the
// next sample can be taken.
// The result sits in an output register with m_tvalid until taken; the next
// sample may be accepted and processed meanwhile, and only its final
// normalization step waits for the output register to free up.
// Reset returns the sequencer to idle and drops any pending result.
// ----------------------------------------------------------------------------
module fractal_value_noise_2d #(
  parameter int MAX_OCTAVES     = 8,
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // x_coord[23:0], y_coord[47:24], seed[67:48], octave_count[71:68]
  input  logic [71:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // noise_value[15:0]
  output logic [15:0] m_tdata
);

  fvn_pkg::cmd_t cmd;

  fvn_ctrl #(
    .MAX_OCTAVES(MAX_OCTAVES)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .octave_count (s_tdata[71:68]),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .cmd          (cmd)
  );

  fvn_datapath #(
    .MAX_OCTAVES     (MAX_OCTAVES),
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_datapath (
    .clk         (clk),
    .cmd         (cmd),
    .x_coord     (s_tdata[23:0]),
    .y_coord     (s_tdata[47:24]),
    .seed        (s_tdata[67:48]),
    .noise_value (m_tdata)
  );

endmodule

// ===== sv/fvn_ctrl.sv =====
// ----------------------------------------------------------------------------
// fvn_ctrl
// Sequencer: walks the step program once per octave and owns the handshakes.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fvn_ctrl #(
  parameter int MAX_OCTAVES = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [3:0]    octave_count,
  output logic          m_tvalid,
  input  logic          m_tready,
  output fvn_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  state_t state, state_next;
  logic [fvn_pkg::STEP_W-1:0] step, step_next;
  logic [fvn_pkg::OCT_W-1:0]  oct, oct_next;
  logic [fvn_pkg::OCT_W-1:0]  oct_last, oct_last_next;
  logic out_valid, out_valid_next;
  logic accept;
  logic fin_go;
  logic [4:0] cnt_clamp;
  logic [4:0] cnt_m1;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign m_tvalid = out_valid;
  assign fin_go   = (state == ST_FIN) && (!out_valid || m_tready);

  always_comb begin
    if (octave_count == 4'd0) begin
      cnt_clamp = 5'd1;
    end else if ({1'b0, octave_count} > 5'(MAX_OCTAVES)) begin
      cnt_clamp = 5'(MAX_OCTAVES);
    end else begin
      cnt_clamp = {1'b0, octave_count};
    end
    cnt_m1 = cnt_clamp - 5'd1;
  end

  always_comb begin
    state_next     = state;
    step_next      = step;
    oct_next       = oct;
    oct_last_next  = oct_last;
    out_valid_next = out_valid && !m_tready;
    cmd.op  = fvn_pkg::OP_NOP;
    cmd.sel = 2'd0;
    cmd.oct = oct;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd.op        = fvn_pkg::OP_LOAD;
          oct_last_next = cnt_m1[fvn_pkg::OCT_W-1:0];
          oct_next      = '0;
          step_next     = '0;
          state_next    = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd     = fvn_pkg::step_cmd(step);
        cmd.oct = oct;
        if (step == fvn_pkg::LAST_STEP) begin
          step_next = '0;
          if (oct == oct_last) begin
            state_next = ST_FIN;
          end else begin
            oct_next = oct + fvn_pkg::OCT_W'(1);
          end
        end else begin
          step_next = step + fvn_pkg::STEP_W'(1);
        end
      end
      ST_FIN: begin
        cmd.oct = oct_last;
        if (fin_go) begin
          cmd.op         = fvn_pkg::OP_FIN;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      oct       <= '0;
      oct_last  <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      oct       <= oct_next;
      oct_last  <= oct_last_next;
      out_valid <= out_valid_next;
    end
  end

  `ASSERT_SYNC(a_fin_free, clk, rst, (cmd.op == fvn_pkg::OP_FIN) |-> (!out_valid || m_tready))
  `ASSERT_SYNC(a_start, clk, rst, accept |=> (state == ST_RUN && step == '0 && oct == '0))
  `ASSERT_SYNC(a_oct_range, clk, rst, (state == ST_RUN) |-> (oct <= oct_last))

endmodule

// ===== sv/fvn_datapath.sv =====
// ----------------------------------------------------------------------------
// fvn_datapath
// Coordinate scaling, lattice hash, smoothstep, blends and normalization,
// all built around one shared multiplier driven by the sequencer commands.
// ----------------------------------------------------------------------------
module fvn_datapath #(
  parameter int MAX_OCTAVES     = 8,
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic          clk,
  input  fvn_pkg::cmd_t cmd,
  input  logic [23:0]   x_coord,
  input  logic [23:0]   y_coord,
  input  logic [19:0]   seed,
  output logic [15:0]   noise_value
);

  localparam int FRAC = COORD_FRAC_BITS;
  localparam int AW   = 32 + MAX_OCTAVES;
  localparam int SW   = 24 + MAX_OCTAVES;
  localparam int OW   = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;

  logic [24:0] recip_tab [MAX_OCTAVES];

  // Normalization reciprocals 2^(n-1) / (2^n - 1) in Q1.24.
  for (genvar g = 0; g < MAX_OCTAVES; g++) begin : g_recip
    localparam logic [63:0] RV = (64'd1 << (g + 24)) / ((64'd1 << (g + 1)) - 64'd1);
    assign recip_tab[g] = RV[24:0];
  end

  logic [23:0] xr, yr;
  logic [19:0] sd;
  logic [AW-1:0] acc;
  logic [47:0] tmp;
  logic [31:0] nreg;
  logic [31:0] c00, c10, c01, c11, r0, r1, v;
  logic [15:0] sx, sy;
  logic [15:0] res;

  logic [OW-1:0] oct_i;
  logic [SW-1:0] xs, ys;
  logic [SW+31:0] xw, yw;
  logic [31:0] cx, cy, cxk, cyk, sdi, base;
  logic [FRAC+15:0] fxw, fyw;
  logic [15:0] tx, ty, tsel;
  logic [31:0] bl_a, bl_b;
  logic [15:0] bl_s;
  logic [32:0] ws;
  logic [32:0] ma;
  logic [31:0] mb;
  logic [64:0] mp;
  logic [47:0] bsum;
  logic [31:0] hv;
  logic [OW-1:0] acc_sh;

  assign oct_i = cmd.oct[OW-1:0];
  assign xs = SW'(xr) << oct_i;
  assign ys = SW'(yr) << oct_i;
  assign xw = {32'd0, xs} >> FRAC;
  assign yw = {32'd0, ys} >> FRAC;
  assign cx = xw[31:0];
  assign cy = yw[31:0];
  // The fraction is realigned to 16 bits whichever side of 16 FRAC lies.
  assign fxw = {xs[FRAC-1:0], 16'd0};
  assign fyw = {ys[FRAC-1:0], 16'd0};
  assign tx = fxw[FRAC+15 -: 16];
  assign ty = fyw[FRAC+15 -: 16];

  assign cxk  = cx + 32'(cmd.sel[0]);
  assign cyk  = cy + 32'(cmd.sel[1]);
  assign sdi  = 32'(sd) + 32'(cmd.oct);
  assign base = cxk + cyk * 32'd57 + sdi * 32'd131;

  assign ws     = acc[AW-1:MAX_OCTAVES-1];
  assign acc_sh = OW'(MAX_OCTAVES - 1) - oct_i;

  always_comb begin
    case (cmd.sel)
      2'd0: begin
        bl_a = c00;
        bl_b = c10;
        bl_s = sx;
      end
      2'd1: begin
        bl_a = c01;
        bl_b = c11;
        bl_s = sx;
      end
      default: begin
        bl_a = r0;
        bl_b = r1;
        bl_s = sy;
      end
    endcase
  end

  always_comb begin
    tsel = (cmd.op == fvn_pkg::OP_SY_SQ || cmd.op == fvn_pkg::OP_SY_MUL) ? ty : tx;
    ma = '0;
    mb = '0;
    case (cmd.op)
      fvn_pkg::OP_SX_SQ, fvn_pkg::OP_SY_SQ: begin
        ma = 33'(tsel);
        mb = 32'(tsel);
      end
      fvn_pkg::OP_SX_MUL, fvn_pkg::OP_SY_MUL: begin
        ma = 33'(tmp[31:0]);
        mb = 32'(18'd196608 - {1'b0, tsel, 1'b0});
      end
      fvn_pkg::OP_H1: begin
        ma = 33'(nreg);
        mb = nreg;
      end
      fvn_pkg::OP_H2: begin
        ma = 33'(tmp[31:0]);
        mb = fvn_pkg::HASH_MUL_A;
      end
      fvn_pkg::OP_H3: begin
        ma = 33'(nreg);
        mb = tmp[31:0];
      end
      fvn_pkg::OP_BLA: begin
        ma = 33'(bl_a);
        mb = 32'(17'h10000 - {1'b0, bl_s});
      end
      fvn_pkg::OP_BLB: begin
        ma = 33'(bl_b);
        mb = 32'(bl_s);
      end
      fvn_pkg::OP_FIN: begin
        ma = ws;
        mb = 32'(recip_tab[oct_i]);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign mp   = 65'(ma) * 65'(mb);
  assign bsum = tmp + mp[47:0];
  assign hv   = mp[31:0] + fvn_pkg::HASH_ADD_B;

  always_ff @(posedge clk) begin
    case (cmd.op)
      fvn_pkg::OP_LOAD: begin
        xr  <= x_coord;
        yr  <= y_coord;
        sd  <= seed;
        acc <= '0;
      end
      fvn_pkg::OP_SX_SQ, fvn_pkg::OP_SY_SQ: tmp <= 48'(mp[31:0]);
      fvn_pkg::OP_SX_MUL: sx <= mp[47:32];
      fvn_pkg::OP_SY_MUL: sy <= mp[47:32];
      fvn_pkg::OP_HN: nreg <= (base << 13) ^ base;
      fvn_pkg::OP_H1: tmp <= 48'(mp[31:0]);
      fvn_pkg::OP_H2: tmp <= 48'(mp[31:0] + fvn_pkg::HASH_ADD_A);
      fvn_pkg::OP_H3: begin
        case (cmd.sel)
          2'd0:    c00 <= fvn_pkg::CORNER_ONE - {1'b0, hv[30:0]};
          2'd1:    c10 <= fvn_pkg::CORNER_ONE - {1'b0, hv[30:0]};
          2'd2:    c01 <= fvn_pkg::CORNER_ONE - {1'b0, hv[30:0]};
          default: c11 <= fvn_pkg::CORNER_ONE - {1'b0, hv[30:0]};
        endcase
      end
      fvn_pkg::OP_BLA: tmp <= mp[47:0];
      fvn_pkg::OP_BLB: begin
        case (cmd.sel)
          2'd0:    r0 <= bsum[47:16];
          2'd1:    r1 <= bsum[47:16];
          default: v  <= bsum[47:16];
        endcase
      end
      fvn_pkg::OP_ACC: acc <= acc + (AW'(v) << acc_sh);
      fvn_pkg::OP_FIN: res <= (|mp[57:55]) ? 16'hffff : mp[54:39];
      default: begin
      end
    endcase
  end

  assign noise_value = res;

endmodule

// ===== test/tb_fractal_value_noise_2d.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fractal_value_noise_2d
// Drives sample beats into the noise block, predicts every result with a
// behavioral fBm value noise model and compares the results in order.
// ----------------------------------------------------------------------------
module tb_fractal_value_noise_2d;

  localparam int MAX_OCT    = 8;
  localparam int FRAC_BITS  = 16;
  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_LEN    = 3000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;

  logic [71:0] sample_q[$];
  logic [15:0] noise_q[$];
  int          send_idle_pct = 11;
  int          recv_idle_pct = 87;
  logic        s_fire = 1'b0;
  logic        hold_start = 1'b0;
  logic        hold_done = 1'b0;
  int          hold_cnt = 0;
  int          errors = 0;
  int          quiet_cycles = 0;

  fractal_value_noise_2d i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #5 clk = ~clk;

  function automatic logic [63:0] lattice_value(logic [31:0] cx, logic [31:0] cy,
                                                logic [31:0] sd);
    logic [31:0] n;
    logic [31:0] h;
    n = cx + cy * 32'd57 + sd * 32'd131;
    n = (n << 13) ^ n;
    h = (n * (n * n * 32'd15731 + 32'd789221) + 32'd1376312589) & 32'h7fffffff;
    return 64'h8000_0000 - {32'd0, h};
  endfunction

  function automatic logic [63:0] smooth(logic [63:0] frac);
    logic [63:0] t;
    t = frac & 64'hffff;
    return ((t * t) * (64'd196608 - 64'd2 * t)) >> 32;
  endfunction

  function automatic logic [63:0] mix(logic [63:0] a, logic [63:0] b, logic [63:0] s);
    return (a * (64'd65536 - s) + b * s) >> 16;
  endfunction

  function automatic logic [15:0] fbm_noise(logic [71:0] d);
    logic [63:0] x, y, xs, ys, sx, sy, acc, ws, recip, res, r0, r1;
    logic [31:0] cx, cy, sd;
    int cnt;
    x = 64'(d[23:0]);
    y = 64'(d[47:24]);
    cnt = int'(d[71:68]);
    if (cnt == 0) cnt = 1;
    if (cnt > MAX_OCT) cnt = MAX_OCT;
    acc = 0;
    for (int i = 0; i < cnt; i++) begin
      sd = {12'd0, d[67:48]} + i;
      xs = x << i;
      ys = y << i;
      cx = 32'(xs >> FRAC_BITS);
      cy = 32'(ys >> FRAC_BITS);
      sx = smooth(xs);
      sy = smooth(ys);
      r0 = mix(lattice_value(cx, cy, sd), lattice_value(cx + 1, cy, sd), sx);
      r1 = mix(lattice_value(cx, cy + 1, sd), lattice_value(cx + 1, cy + 1, sd), sx);
      acc += mix(r0, r1, sy) << (MAX_OCT - 1 - i);
    end
    ws = acc >> (MAX_OCT - 1);
    recip = (64'd1 << (cnt + 23)) / ((64'd1 << cnt) - 1);
    res = (ws * recip) >> 39;
    if (res > 65535) res = 65535;
    return res[15:0];
  endfunction

  function automatic logic [71:0] pack_sample(logic [23:0] x, logic [23:0] y,
                                              logic [19:0] sd, logic [3:0] oc);
    return {oc, sd, y, x};
  endfunction

  // Mostly few octaves so the run stays short; full counts appear now and then.
  function automatic logic [3:0] rand_octaves();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 4'($urandom_range(0, 3));
    return 4'($urandom_range(0, 15));
  endfunction

  // Driver: at the falling edge, retire the beat taken at the last rising edge
  // and present the next sample if any.
  always @(negedge clk) begin
    if (!rst) begin
      if (s_fire) begin
        sample_q.pop_front();
      end
      if (sample_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        s_tvalid <= 1'b1;
        s_tdata  <= sample_q[0];
      end else if (!(s_tvalid && !s_fire)) begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure, with one long hold-off counted here.
  always @(negedge clk) begin
    if (!rst) begin
      if (hold_start && !hold_done) begin
        m_tready <= 1'b0;
        if (hold_cnt >= HOLD_LEN - 1) begin
          hold_done <= 1'b1;
        end
        hold_cnt <= hold_cnt + 1;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Monitor: sample handshakes at the rising edge, check results in order and stop on a stall.
  always @(posedge clk) begin
    if (!rst) begin
      s_fire <= s_tvalid && s_tready;
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (s_tvalid && s_tready) begin
        noise_q.push_back(fbm_noise(s_tdata));
      end
      if (m_tvalid && m_tready) begin
        if (noise_q.size() == 0) begin
          $error("unexpected result noise_value actual %0d", m_tdata);
          errors <= errors + 1;
        end else begin
          if (m_tdata !== noise_q[0]) begin
            $error("noise_value expected %0d actual %0d", noise_q[0], m_tdata);
            errors <= errors + 1;
          end
          noise_q.pop_front();
        end
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic drain();
    while (sample_q.size() != 0 || s_tvalid || noise_q.size() != 0) @(posedge clk);
  endtask

  task automatic queue_random(int n);
    logic [23:0] x, y;
    for (int k = 0; k < n; k++) begin
      x = 24'($urandom());
      y = 24'($urandom());
      // Keep some samples near lattice corners and edges.
      if ($urandom_range(0, 9) == 0) x[15:0] = $urandom_range(0, 1) ? 16'h0 : 16'hffff;
      if ($urandom_range(0, 9) == 0) y[15:0] = $urandom_range(0, 1) ? 16'h0 : 16'hffff;
      sample_q.push_back(pack_sample(x, y, 20'($urandom()), rand_octaves()));
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    // Directed: field extremes, zero and excess octave counts, wrap of the lattice.
    for (int oc = 0; oc < 16; oc++)
      sample_q.push_back(pack_sample(24'($urandom()), 24'($urandom()),
                                     20'($urandom()), 4'(oc)));
    sample_q.push_back(pack_sample(24'h0, 24'h0, 20'h0, 4'd1));
    sample_q.push_back(pack_sample(24'hffffff, 24'hffffff, 20'hfffff, 4'd8));
    sample_q.push_back(pack_sample(24'hffffff, 24'h0, 20'hfffff, 4'd15));
    sample_q.push_back(pack_sample(24'h0, 24'hffffff, 20'h0, 4'd0));
    sample_q.push_back(pack_sample(24'h00ffff, 24'h010000, 20'h80000, 4'd2));
    sample_q.push_back(pack_sample(24'h008000, 24'h008000, 20'h12345, 4'd8));
    drain();
    // Long receiver hold-off while the sender keeps offering.
    hold_start = 1'b1;
    queue_random(20);
    drain();
    queue_random(380);
    drain();
    send_idle_pct = 87;
    recv_idle_pct = 11;
    queue_random(380);
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(350);
    drain();
    repeat (300) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/fvn_pkg.sv
sv/fvn_ctrl.sv
sv/fvn_datapath.sv
sv/fractal_value_noise_2d.sv
test/tb_fractal_value_noise_2d.sv
